// ----- rtl/meu_pkg.sv -----
package meu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 6;
  localparam logic [WordW-1:0] DivZeroWord = 32'h7fffffff;
  localparam logic [WordW-1:0] LinkOffset = 32'd8;

  localparam logic [KindW-1:0] K_ADD = 6'd0, K_SUB = 6'd1, K_AND = 6'd2, K_OR = 6'd3,
    K_XOR = 6'd4, K_NOR = 6'd5, K_SLT = 6'd6, K_SLTU = 6'd7, K_SLL = 6'd8, K_SRL = 6'd9,
    K_SRA = 6'd10, K_SLLV = 6'd11, K_SRLV = 6'd12, K_SRAV = 6'd13, K_ADDI = 6'd14,
    K_SLTI = 6'd15, K_SLTIU = 6'd16, K_LUI = 6'd17, K_MULT = 6'd18, K_MULTU = 6'd19,
    K_DIV = 6'd20, K_DIVU = 6'd21, K_MFHI = 6'd22, K_MFLO = 6'd23, K_MTHI = 6'd24,
    K_MTLO = 6'd25, K_BEQ = 6'd26, K_BNE = 6'd27, K_BLEZ = 6'd28, K_BGTZ = 6'd29,
    K_BLTZ = 6'd30, K_BGEZ = 6'd31, K_BLTZAL = 6'd32, K_BGEZAL = 6'd33, K_J = 6'd34,
    K_JR = 6'd35, K_JAL = 6'd36, K_ADDR = 6'd37;

  // per-item record flowing down the cell chain
  typedef struct packed {
    logic             is_div;
    logic             neg_q;
    logic             neg_r;
    logic             special;
    logic [WordW-1:0] rem;
    logic [WordW-1:0] quo;
    logic [WordW-1:0] dvs;
    logic [WordW-1:0] res_lo;
    logic [WordW-1:0] res_hi;
    logic             taken;
    logic [WordW-1:0] addr;
  } meu_item_t;

endpackage

// ----- rtl/meu_div_cell.sv -----
module meu_div_cell #(
  parameter int unsigned BitsPerCell = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  meu_pkg::meu_item_t item_in,
  input  logic              advance,
  output logic              valid_out,
  output meu_pkg::meu_item_t item_out
);
  import meu_pkg::*;

  meu_item_t item_next;
  logic [WordW:0] trial;
  logic [WordW-1:0] r, q;

  always_comb begin
    item_next = item_in;
    r = item_in.rem;
    q = item_in.quo;
    trial = '0;
    for (int i = 0; i < BitsPerCell; i++) begin
      trial = {r, q[WordW-1]} - {1'b0, item_in.dvs};
      q = {q[WordW-2:0], ~trial[WordW]};
      r = trial[WordW] ? {r[WordW-2:0], item_next.quo[WordW-1]} : trial[WordW-1:0];
      item_next.quo = {item_next.quo[WordW-2:0], 1'b0};
    end
    if (item_in.is_div) begin
      item_next.rem = r;
      item_next.quo = q;
    end else begin
      item_next.quo = item_in.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
    if (advance) begin
      item_out <= item_next;
    end
  end
endmodule

// ----- rtl/meu_front.sv -----
module meu_front (
  input  logic [meu_pkg::KindW-1:0] kind,
  input  logic [meu_pkg::WordW-1:0] src_a,
  input  logic [meu_pkg::WordW-1:0] src_b,
  input  logic [4:0]                shift_amount,
  input  logic [meu_pkg::WordW-1:0] pc_value,
  input  logic [meu_pkg::WordW-1:0] hi_in,
  input  logic [meu_pkg::WordW-1:0] lo_in,
  output meu_pkg::meu_item_t        item
);
  import meu_pkg::*;

  logic [WordW-1:0] imm, link, ua, ub;
  logic [2*WordW-1:0] prod;
  logic signed [2*WordW+1:0] prod_wide;
  logic sa, sb;

  assign imm  = {{16{src_b[15]}}, src_b[15:0]};
  assign link = pc_value + LinkOffset;
  assign sa   = (kind == K_MULT) && src_a[WordW-1];
  assign sb   = (kind == K_MULT) && src_b[WordW-1];
  assign prod_wide = $signed({sa, src_a}) * $signed({sb, src_b});
  assign prod = prod_wide[2*WordW-1:0];
  assign ua   = (kind == K_DIV && src_a[WordW-1]) ? -src_a : src_a;
  assign ub   = (kind == K_DIV && src_b[WordW-1]) ? -src_b : src_b;

  always_comb begin
    item = '0;
    item.addr = src_a + imm;
    unique case (kind)
      K_ADD:   item.res_lo = src_a + src_b;
      K_SUB:   item.res_lo = src_a - src_b;
      K_AND:   item.res_lo = src_a & src_b;
      K_OR:    item.res_lo = src_a | src_b;
      K_XOR:   item.res_lo = src_a ^ src_b;
      K_NOR:   item.res_lo = ~(src_a | src_b);
      K_SLT:   item.res_lo = WordW'($signed(src_a) < $signed(src_b));
      K_SLTU:  item.res_lo = WordW'(src_a < src_b);
      K_SLL:   item.res_lo = src_b << shift_amount;
      K_SRL:   item.res_lo = src_b >> shift_amount;
      K_SRA:   item.res_lo = $signed(src_b) >>> shift_amount;
      K_SLLV:  item.res_lo = src_b << src_a[4:0];
      K_SRLV:  item.res_lo = src_b >> src_a[4:0];
      K_SRAV:  item.res_lo = $signed(src_b) >>> src_a[4:0];
      K_ADDI:  item.res_lo = src_a + imm;
      K_SLTI:  item.res_lo = WordW'($signed(src_a) < $signed(imm));
      K_SLTIU: item.res_lo = WordW'(src_a < imm);
      K_LUI:   item.res_lo = {src_b[15:0], 16'h0};
      K_MULT, K_MULTU: begin
        item.res_lo = prod[WordW-1:0];
        item.res_hi = prod[2*WordW-1:WordW];
      end
      K_DIV, K_DIVU: begin
        if (src_b == '0) begin
          item.special = 1'b1;
          item.res_lo  = DivZeroWord;
          item.res_hi  = DivZeroWord;
        end else begin
          item.is_div = 1'b1;
          item.quo    = ua;
          item.dvs    = ub;
          item.neg_q  = (kind == K_DIV) && (src_a[WordW-1] ^ src_b[WordW-1]);
          item.neg_r  = (kind == K_DIV) && src_a[WordW-1];
        end
      end
      K_MFHI:  item.res_lo = hi_in;
      K_MFLO:  item.res_lo = lo_in;
      K_MTHI:  item.res_hi = src_a;
      K_MTLO:  item.res_lo = src_a;
      K_BEQ:   item.taken = (src_a == src_b);
      K_BNE:   item.taken = (src_a != src_b);
      K_BLEZ:  item.taken = src_a[WordW-1] || (src_a == '0);
      K_BGTZ:  item.taken = !src_a[WordW-1] && (src_a != '0);
      K_BLTZ:  item.taken = src_a[WordW-1];
      K_BGEZ:  item.taken = !src_a[WordW-1];
      K_BLTZAL: begin item.taken = src_a[WordW-1]; item.res_lo = link; end
      K_BGEZAL: begin item.taken = !src_a[WordW-1]; item.res_lo = link; end
      K_J, K_JR: item.taken = 1'b1;
      K_JAL:   begin item.taken = 1'b1; item.res_lo = link; end
      default: ;
    endcase
    if (kind != K_ADDR) item.addr = '0;
  end
endmodule

// ----- rtl/mips_execute_unit.sv -----
// channel | signals                                              | dir
// in      | valid ready kind src_a src_b shift_amount pc_value hi_in lo_in | in
// out     | out_valid out_ready result_low result_high branch_taken mem_address | out
// one beat per cycle while the output is empty or out_ready is high
// the depth is set by the divide cell chain, each cell retiring BitsPerCell quotient bits
// the multiply completes in the entry cycle; every kind flows through the same chain
// a stall at the output freezes the whole chain; rst empties it
module mips_execute_unit #(
  parameter int unsigned BitsPerCell = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [5:0]  kind,
  input  logic [31:0] src_a,
  input  logic [31:0] src_b,
  input  logic [4:0]  shift_amount,
  input  logic [31:0] pc_value,
  input  logic [31:0] hi_in,
  input  logic [31:0] lo_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_low,
  output logic [31:0] result_high,
  output logic        branch_taken,
  output logic [31:0] mem_address
);
  import meu_pkg::*;

  localparam int unsigned Cells = WordW / BitsPerCell;

  meu_item_t front_item, fix;
  meu_item_t items [Cells+1];
  logic vld [Cells+1];
  logic advance;

  assign advance = !vld[Cells] || out_ready;
  assign ready = advance;

  meu_front u_front (.kind, .src_a, .src_b, .shift_amount, .pc_value, .hi_in, .lo_in,
    .item(front_item));

  assign items[0] = front_item;
  assign vld[0] = valid;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    meu_div_cell #(.BitsPerCell(BitsPerCell)) u_cell (
      .clk, .rst, .valid_in(vld[g]), .item_in(items[g]), .advance,
      .valid_out(vld[g+1]), .item_out(items[g+1]));
  end

  always_comb begin
    fix = items[Cells];
    if (fix.is_div) begin
      fix.res_lo = fix.neg_q ? -fix.quo : fix.quo;
      fix.res_hi = fix.neg_r ? -fix.rem : fix.rem;
    end
  end

  assign out_valid    = vld[Cells];
  assign result_low   = fix.res_lo;
  assign result_high  = fix.res_hi;
  assign branch_taken = fix.taken;
  assign mem_address  = fix.addr;
endmodule

// ----- rtl/meu_checker.sv -----
module meu_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_low,
  input logic [31:0] result_high
);
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready) else $error("ready low with empty output");
  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> ready) else $error("ready low while output drains");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(result_high))
    else $error("output beat changed under stall");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind mips_execute_unit meu_checker u_meu_checker (.clk, .rst, .valid, .ready, .out_valid,
  .out_ready, .result_low, .result_high);
